// ===== hw/rtl/cset_pkg.sv =====
// shared constants, types and codes for the call stack exclusive time profiler
`default_nettype none
package cset_pkg;

  localparam int ID_W        = 6;
  localparam int TIME_W      = 32;
  localparam int TOTAL_W     = 48;
  localparam int FUNCS       = 1 << ID_W;
  localparam int STACK_DEPTH = 64;
  localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
  localparam int SP_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CF_W        = TIME_W + 1;

  localparam int IN_DATA_W   = ((ID_W + TIME_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((ID_W + TOTAL_W + 7) / 8) * 8;

  typedef logic [ID_W-1:0]    id_t;
  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [TOTAL_W:0]   sum_t;
  typedef logic [CF_W-1:0]    cf_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [SP_W-1:0]    sp_t;

  localparam total_t TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // push / pop request to the id stack
  typedef struct packed {
    logic push;
    logic pop;
    id_t  id;
  } stk_cmd_t;

  // stack condition seen by the event logic
  typedef struct packed {
    logic empty;
    logic full;
    id_t  top;
  } stk_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/call_stack_exclusive_time.sv =====
// top level: exclusive-time profiler over a stream of call start / call end events
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+-------------------------------------------
//   in_      | in  | in_tvalid/in_tready  | tuser: req_type; tdata: func_id, time_stamp
//   out_     | out | out_tvalid/out_tready| tuser: status; tdata: credited_id, total
//
// one event per cycle sustained while the output is not stalled; each beat gives one result beat
// (accept, total table read stage, then the output register)
// the rate is set by the total table read-modify-write: a registered read and a
// write-back as the read stage advances, closed by forwarding of the last written total
// reset clears stack level, charge point and all totals (valid bits, no sweep)
// when out_tready is low and the output register is full the read stage holds, and the
// input stalls only once both the stage and the output register are full
`default_nettype none
module call_stack_exclusive_time (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [cset_pkg::IN_DATA_W-1:0]    in_tdata,   // func_id, time_stamp, zero pad
  input  wire logic                              in_tuser,   // req_type
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [cset_pkg::OUT_DATA_W-1:0]        out_tdata,  // credited_id, exclusive_total, pad
  output logic [1:0]                             out_tuser   // status
);

  // input beat fields
  logic               acc;
  logic               ev_start;
  cset_pkg::id_t      ev_id;
  cset_pkg::time_t    ev_time;

  // stack interface
  cset_pkg::stk_cmd_t  stk_cmd;
  cset_pkg::stk_stat_t stk_stat;

  // charge bookkeeping
  cset_pkg::cf_t      cf_r;
  cset_pkg::cf_t      upto;
  cset_pkg::cf_t      amount;
  logic               chg_en;
  cset_pkg::id_t      rep_id;
  cset_pkg::status_t  ev_status;

  // table read stage
  logic               s1_valid_r;
  logic               s1_chg_en_r;
  cset_pkg::id_t      s1_chg_id_r;
  cset_pkg::id_t      s1_rep_id_r;
  cset_pkg::cf_t      s1_amount_r;
  cset_pkg::status_t  s1_status_r;
  logic               s1_adv;
  logic               out_free;

  // table ports and forwarding of the last write
  cset_pkg::total_t   rd_chg, rd_rep;
  cset_pkg::total_t   chg_cur, rep_cur;
  cset_pkg::sum_t     sum_w;
  cset_pkg::total_t   new_total;
  cset_pkg::total_t   rep_total;
  logic               tot_wr_en;
  logic               fw_valid_r;
  cset_pkg::id_t      fw_id_r;
  cset_pkg::total_t   fw_total_r;

  // output register
  logic               out_valid_r;
  cset_pkg::id_t      out_id_r;
  cset_pkg::total_t   out_total_r;
  cset_pkg::status_t  out_status_r;

  // handshake: the read stage moves whenever the output register frees up
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || s1_adv;
  assign acc       = in_tvalid && in_tready;

  assign ev_start = !in_tuser;
  assign ev_id    = in_tdata[cset_pkg::ID_W-1:0];
  assign ev_time  = in_tdata[cset_pkg::ID_W+cset_pkg::TIME_W-1:cset_pkg::ID_W];

  // event decode against the stack state
  always_comb begin
    stk_cmd.push = acc && ev_start && !stk_stat.full;
    stk_cmd.pop  = acc && !ev_start && !stk_stat.empty;
    stk_cmd.id   = ev_id;

    // an end covers its own tick, so its charge runs up to time_stamp + 1, exclusive
    upto   = cset_pkg::cf_t'(ev_time) + cset_pkg::cf_t'(!ev_start);
    amount = (upto > cf_r) ? (upto - cf_r) : '0;

    if (ev_start) begin
      chg_en    = !stk_stat.full && !stk_stat.empty;
      rep_id    = ev_id;
      ev_status = stk_stat.full ? cset_pkg::ST_OVERFLOW : cset_pkg::ST_OK;
    end else begin
      chg_en    = !stk_stat.empty;
      rep_id    = stk_stat.empty ? ev_id : stk_stat.top;
      ev_status = stk_stat.empty ? cset_pkg::ST_UNDERFLOW : cset_pkg::ST_OK;
    end
  end

  cset_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (stk_cmd),
    .stat  (stk_stat)
  );

  // charge point moves on every push and pop, even when time runs backwards
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cf_r <= '0;
    end else if (stk_cmd.push || stk_cmd.pop) begin
      cf_r <= upto;
    end
  end

  cset_totals u_totals (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (acc),
    .rd_addr_a (stk_stat.top),
    .rd_addr_b (rep_id),
    .rd_data_a (rd_chg),
    .rd_data_b (rd_rep),
    .wr_en     (tot_wr_en),
    .wr_addr   (s1_chg_id_r),
    .wr_data   (new_total)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_chg_en_r <= chg_en;
      s1_chg_id_r <= stk_stat.top;
      s1_rep_id_r <= rep_id;
      s1_amount_r <= amount;
      s1_status_r <= ev_status;
    end
  end

  // modify: the most recent write always wins over the table read
  always_comb begin
    chg_cur   = (fw_valid_r && fw_id_r == s1_chg_id_r) ? fw_total_r : rd_chg;
    rep_cur   = (fw_valid_r && fw_id_r == s1_rep_id_r) ? fw_total_r : rd_rep;
    sum_w     = cset_pkg::sum_t'(chg_cur) + cset_pkg::sum_t'(s1_amount_r);
    new_total = sum_w[cset_pkg::TOTAL_W] ? cset_pkg::TOTAL_MAX
                                         : sum_w[cset_pkg::TOTAL_W-1:0];
    // recursion: a start may report the same function it just charged
    rep_total = (s1_chg_en_r && s1_rep_id_r == s1_chg_id_r) ? new_total : rep_cur;
    tot_wr_en = s1_adv && s1_chg_en_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_valid_r <= 1'b0;
    end else if (tot_wr_en) begin
      fw_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tot_wr_en) begin
      fw_id_r    <= s1_chg_id_r;
      fw_total_r <= new_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_id_r     <= s1_rep_id_r;
      out_total_r  <= rep_total;
      out_status_r <= s1_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = cset_pkg::OUT_DATA_W'({out_total_r, out_id_r});
  assign out_tuser  = out_status_r;

`ifndef SYNTHESIS
  a_push_pop_excl : assert property (@(posedge clk) disable iff (!rst_n)
    !(stk_cmd.push && stk_cmd.pop))
    else $error("push and pop in the same cycle");

  a_no_push_full : assert property (@(posedge clk) disable iff (!rst_n)
    stk_stat.full |-> !stk_cmd.push)
    else $error("push into a full stack");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a full pipeline");

  a_flag_no_charge : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_status_r != cset_pkg::ST_OK) |-> !s1_chg_en_r)
    else $error("flagged event charges a total");

  a_push_level : assert property (@(posedge clk) disable iff (!rst_n)
    stk_cmd.push |=> !stk_stat.empty)
    else $error("stack empty after a push");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/cset_stack.sv =====
// id stack: synchronous memory with a cached top and a prefetched second entry
`default_nettype none
module cset_stack (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cset_pkg::stk_cmd_t   cmd,
  output cset_pkg::stk_stat_t       stat
);

  cset_pkg::id_t    mem [cset_pkg::STACK_DEPTH];
  cset_pkg::level_t level_r, level_nxt;
  cset_pkg::id_t    top_r, top_nxt;
  cset_pkg::id_t    under_r;
  cset_pkg::level_t below_lvl;
  cset_pkg::sp_t    rd_addr;
  cset_pkg::sp_t    wr_addr;

  always_comb begin
    level_nxt = level_r;
    top_nxt   = top_r;
    if (cmd.push) begin
      level_nxt = level_r + cset_pkg::level_t'(1);
      top_nxt   = cmd.id;
    end else if (cmd.pop) begin
      level_nxt = level_r - cset_pkg::level_t'(1);
      top_nxt   = under_r;
    end
  end

  // prefetch the entry under the next top so a pop can follow at once
  always_comb begin
    below_lvl = level_nxt - cset_pkg::level_t'(2);
    rd_addr   = (level_nxt >= cset_pkg::level_t'(2)) ? below_lvl[cset_pkg::SP_W-1:0] : '0;
    wr_addr   = level_r[cset_pkg::SP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= cmd.id;
    end
    under_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else begin
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
  end

  assign stat.empty = (level_r == '0);
  assign stat.full  = (level_r == cset_pkg::level_t'(cset_pkg::STACK_DEPTH));
  assign stat.top   = top_r;

endmodule
`default_nettype wire

// ===== hw/rtl/cset_totals.sv =====
// per-function total table: one write port, two registered read ports, valid bits
`default_nettype none
module cset_totals (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                rd_en,
  input  wire cset_pkg::id_t       rd_addr_a,
  input  wire cset_pkg::id_t       rd_addr_b,
  output cset_pkg::total_t         rd_data_a,
  output cset_pkg::total_t         rd_data_b,
  input  wire logic                wr_en,
  input  wire cset_pkg::id_t       wr_addr,
  input  wire cset_pkg::total_t    wr_data
);

  cset_pkg::total_t           mem [cset_pkg::FUNCS];
  logic [cset_pkg::FUNCS-1:0] valid_r;
  cset_pkg::total_t           rd_a_r, rd_b_r;
  logic                       va_r, vb_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
      va_r   <= valid_r[rd_addr_a];
      vb_r   <= valid_r[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // entries never written read as zero
  assign rd_data_a = va_r ? rd_a_r : '0;
  assign rd_data_b = vb_r ? rd_b_r : '0;

endmodule
`default_nettype wire

// ===== tb/cset_tb_pkg.sv =====
// event kind codes shared by the profiler testbench files
`timescale 1ns / 100ps
package cset_tb_pkg;

  // req_type as carried on in_tuser
  typedef enum logic {
    EV_START = 1'b0,
    EV_END   = 1'b1
  } event_kind_t;

endpackage

// ===== tb/exclusive_time_checker.sv =====
// checker: predicts exclusive-time totals per event and compares the result beats
`timescale 1ns / 100ps
module exclusive_time_checker
  import cset_pkg::*;
  import cset_tb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  in_tuser,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,
  input  wire logic [1:0]            out_tuser,
  output int                         failures,
  output int                         awaiting
);

  typedef struct packed {
    id_t     id;
    total_t  total;
    status_t status;
  } credit_t;

  id_t     call_ids [STACK_DEPTH];
  int      open_depth;
  cf_t     charged_upto;
  total_t  func_totals [FUNCS];
  credit_t credits_due [$];

  // charge ticks [charged_upto, upto) to one function, clamped at zero and saturating
  function automatic void add_span(id_t fid, cf_t upto);
    total_t span;
    sum_t   sum;
    span = (upto > charged_upto) ? total_t'(upto - charged_upto) : '0;
    sum  = {1'b0, func_totals[fid]} + {1'b0, span};
    func_totals[fid] = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  endfunction

  function automatic credit_t account_event(event_kind_t kind, id_t fid, time_t stamp);
    credit_t c;
    cf_t     t;
    t        = {1'b0, stamp};
    c.id     = fid;
    c.status = ST_OK;
    if (kind == EV_START) begin
      if (open_depth >= STACK_DEPTH) begin
        c.status = ST_OVERFLOW;
      end else begin
        if (open_depth > 0) add_span(call_ids[open_depth-1], t);
        call_ids[open_depth] = fid;
        open_depth++;
        charged_upto = t;
      end
    end else if (open_depth == 0) begin
      c.status = ST_UNDERFLOW;
    end else begin
      // the end event's own id plays no part
      open_depth--;
      c.id = call_ids[open_depth];
      add_span(c.id, t + 1'b1);
      charged_upto = t + 1'b1;
    end
    c.total = func_totals[c.id];
    return c;
  endfunction

  always @(posedge clk) begin
    credit_t got;
    credit_t want;
    credit_t fresh;
    if (!rst_n) begin
      open_depth   = 0;
      charged_upto = '0;
      for (int i = 0; i < FUNCS; i++) func_totals[i] = '0;
      credits_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.id     = out_tdata[ID_W-1:0];
        got.total  = out_tdata[ID_W +: TOTAL_W];
        got.status = status_t'(out_tuser);
        if (credits_due.size() == 0) begin
          failures++;
          $display("%0t: unexpected result beat id %0d total %0d status %0d",
                   $time, got.id, got.total, got.status);
        end else begin
          want = credits_due.pop_front();
          if (got.id !== want.id) begin
            failures++;
            $display("%0t: credited_id expected %0d got %0d", $time, want.id, got.id);
          end
          if (got.total !== want.total) begin
            failures++;
            $display("%0t: exclusive_total expected %0d got %0d",
                     $time, want.total, got.total);
          end
          if (got.status !== want.status) begin
            failures++;
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        fresh       = account_event(event_kind_t'(in_tuser),
                                    in_tdata[ID_W-1:0], in_tdata[ID_W +: TIME_W]);
        credits_due = {credits_due, fresh};
      end
    end
    awaiting = credits_due.size();
  end

endmodule

// ===== tb/testbench.sv =====
// testbench top: event stimulus for the exclusive-time profiler and the final verdict
`timescale 1ns / 100ps
module testbench;
  import cset_pkg::*;
  import cset_tb_pkg::*;

  // about this many events before the final unwind
  localparam int TRACE_EVENTS   = 1500;
  // event count below which the random part runs with no idling on either side
  localparam int STEADY_UNTIL   = 350;
  localparam int CYCLE_LIMIT    = 100_000;
  // idle time after the last result is back, to catch stray beats
  localparam int DRAIN_CYCLES   = 10;
  localparam int IDLE_PCT       = 38;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = EV_START;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;

  int    failures;
  int    awaiting;
  bit    steady       = 1'b0;  // no idling on either side while set
  int    open_calls   = 0;     // stack level as the stimulus sees it, for shaping only
  int    events_sent  = 0;
  int    cycle_count  = 0;
  time_t trace_clock  = '0;    // running timestamp of the synthetic trace

  call_stack_exclusive_time dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  exclusive_time_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .failures   (failures),
    .awaiting   (awaiting)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side back-pressure, changed on the falling edge
  always @(negedge clk)
    out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("call_stack_exclusive_time verification failed");
      $finish;
    end
  end

  // one event beat; called at a falling edge, returns at a falling edge after the accept
  task automatic send_event(event_kind_t kind, id_t fid, time_t stamp);
    logic [IN_DATA_W-1:0] beat;
    beat                  = '0;
    beat[ID_W-1:0]        = fid;
    beat[ID_W +: TIME_W]  = stamp;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= beat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    events_sent++;
    if (kind == EV_START && open_calls < STACK_DEPTH) open_calls++;
    if (kind == EV_END && open_calls > 0) open_calls--;
  endtask

  // hold the sender off until every result beat is back
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (awaiting != 0);
  endtask

  // mostly forward steps, some repeats, some backward jumps, some wild values
  function automatic time_t next_stamp();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70)      trace_clock = trace_clock + $urandom_range(1, 40);
    else if (pick < 80) trace_clock = trace_clock + $urandom_range(0, 2);
    else if (pick < 88) trace_clock = trace_clock - $urandom_range(1, 100);
    else if (pick < 95) trace_clock = $urandom();
    else                trace_clock = $urandom_range(1) ? '1 : '0;
    return trace_clock;
  endfunction

  function automatic id_t pick_id();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return id_t'($urandom_range(FUNCS - 1));
  endfunction

  initial begin
    int   style;
    int   push_pct;
    id_t  hot_id;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: underflow on an empty stack, nesting, backward time, extreme stamps
    send_event(EV_END,   6'd63, 32'd0);           // underflow right after reset
    send_event(EV_START, 6'd0,  32'd0);
    send_event(EV_START, 6'd63, 32'hFFFF_FFFF);    // charge to id 0 across the full 32-bit stamp range
    send_event(EV_START, 6'd5,  32'd10);           // time backwards, caller gets nothing
    send_event(EV_END,   6'd0,  32'd20);           // inclusive end, id ignored
    send_event(EV_END,   6'd21, 32'hFFFF_FFFF);    // charge point moves past 32 bits
    send_event(EV_START, 6'd42, 32'd7);            // behind the charge point
    send_event(EV_END,   6'd0,  32'd7);
    send_event(EV_END,   6'd63, 32'd100);
    send_event(EV_END,   6'd0,  32'd5);            // underflow with nonzero total
    send_event(EV_START, 6'd42, 32'hAAAA_AAAA);
    send_event(EV_START, 6'd21, 32'h5555_5555);
    send_event(EV_END,   6'd63, 32'h5555_5555);
    send_event(EV_END,   6'd0,  32'hFFFF_FFFF);
    send_event(EV_START, 6'd1,  32'hFFFF_FFFF);
    send_event(EV_END,   6'd1,  32'hFFFF_FFFF);    // one-tick call at the top of time
    send_event(EV_START, 6'd1,  32'd0);
    send_event(EV_END,   6'd62, 32'd0);
    send_event(EV_END,   6'd1,  32'd0);            // underflow again

    // sender pause until the pipe is empty
    wait_quiet();
    trace_clock = 32'd1000;

    // random trace: nesting walks with drift up or down, and full climb-and-unwind runs
    while (events_sent < TRACE_EVENTS) begin
      steady = (events_sent < STEADY_UNTIL);
      style  = $urandom_range(9);
      if (style == 0) begin
        // climb to a full stack, push past it, then unwind past empty
        while (open_calls < STACK_DEPTH) send_event(EV_START, pick_id(), next_stamp());
        repeat ($urandom_range(1, 3)) send_event(EV_START, pick_id(), next_stamp());
        while (open_calls > 0) send_event(EV_END, pick_id(), next_stamp());
        repeat ($urandom_range(1, 3)) send_event(EV_END, pick_id(), next_stamp());
      end else begin
        push_pct = (style < 4) ? 50 : (style < 7) ? 65 : 35;
        repeat ($urandom_range(20, 60)) begin
          if ($urandom_range(99) < push_pct)
            send_event(EV_START, pick_id(), next_stamp());
          else
            send_event(EV_END, pick_id(), next_stamp());
        end
      end
    end
    steady = 1'b0;

    // unwind, then let all results come home
    while (open_calls > 0) send_event(EV_END, pick_id(), next_stamp());
    wait_quiet();

    // caller charged a full span by a nested call, then both popped
    hot_id = pick_id();
    send_event(EV_START, hot_id, 32'd0);
    send_event(EV_START, pick_id(), 32'hFFFF_FFFF);
    send_event(EV_END, pick_id(), 32'hFFFF_FFFF);
    send_event(EV_END, pick_id(), 32'hFFFF_FFFF);

    wait_quiet();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (failures == 0)
      $display("call_stack_exclusive_time verification clean");
    else
      $display("call_stack_exclusive_time verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cset_pkg.sv
hw/rtl/cset_stack.sv
hw/rtl/cset_totals.sv
hw/rtl/call_stack_exclusive_time.sv
tb/cset_tb_pkg.sv
tb/exclusive_time_checker.sv
tb/testbench.sv
